FILE: hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

	localparam int HEAP_BYTES_DEF = 32768;
	localparam logic [15:0] LIMIT_RESET = 16'd32768;
	localparam int HDR_BYTES = 8;
	localparam int MIN_SPLIT = 16;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_RESIZE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		OUT_DONE  = 2'd0,
		OUT_NOMEM = 2'd1,
		OUT_MOVED = 2'd2
	} outcome_t;

	// which request the shared walk is serving
	typedef enum logic [1:0] {
		M_ALLOC,
		M_FREE,
		M_RESIZE,
		M_MOVE
	} mode_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_CH_CHK,
		S_CH_ADV,
		S_RS_PREV,
		S_RS_CHK,
		S_RS_EVAL,
		S_RS_TOP,
		S_AL_CHK,
		S_AL_EVAL,
		S_SPLIT1,
		S_SPLIT2,
		S_AL_DONE,
		S_REL_RD,
		S_REL_SZ,
		S_REL_CHK,
		S_REL_NX,
		S_REL_WR,
		S_FIN
	} state_t;

endpackage

FILE: hw/rtl/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// a request that needs no walk goes from decode straight to the result; otherwise fixed steps
// run, plus the walk states once per header visited on each walk of the block chain
// a move walks the chain up to four times; a result that waits on m_tready adds its wait
// throughput: one transaction at a time; the next is taken the cycle after the result is registered
// reset: heap top cleared, heap limit set to 32768; header memory is not cleared
// and holds nothing meaningful until headers are written
module first_fit_heap_allocator_top
	import ffha_pkg::*;
#(
	parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,      // heap_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,       // op[1:0], req_size[17:2], block_addr[33:18], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata        // result_addr[15:0], outcome[17:16],
	                                   // copy_from[33:18], copy_bytes[49:34], zero fill
);

	localparam int SLOTS  = HEAP_BYTES / HDR_BYTES;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int AW     = (SLOT_W + 4 > 18) ? SLOT_W + 4 : 18;

	// header memory: {in-use, payload size}
	logic [16:0] hdr_mem [SLOTS];
	logic [16:0] rd_q;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [16:0] wdata;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic [1:0]    op_q;
	logic [AW-1:0] n_q, h_q, h_d, cur_q, cur_d, acc_q, acc_d, blk_q, blk_d, tot_q, tot_d;
	logic [AW-1:0] na_q, na_d, top_q, top_d;
	logic [15:0]   addr_q, prev_q, prev_d, limit_q;
	logic [15:0]   res_q, res_d, cfrom_q, cfrom_d, cbytes_q, cbytes_d;
	logic [1:0]    outc_q, outc_d;
	logic [15:0]   o_res_q, o_cfrom_q, o_cbytes_q;
	logic [1:0]    o_outc_q;
	logic          o_valid_q;
	logic          load_out;

	logic [AW-1:0] rsize, step, accstep, lim, n_in, fit_rem;
	logic          rused;

	assign rsize   = AW'(rd_q[15:0]);
	assign rused   = rd_q[16];
	// shared walk adder: next header offset after the one just read
	assign step    = cur_q + AW'(HDR_BYTES) + rsize;
	assign accstep = acc_q + AW'(HDR_BYTES) + rsize;
	assign lim     = (AW'(limit_q) > AW'(HEAP_BYTES)) ? AW'(HEAP_BYTES) : AW'(limit_q);
	assign n_in    = (AW'(s_tdata[17:2]) + AW'(7)) & ~AW'(7);
	assign fit_rem = rsize - n_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = o_valid_q;
	assign m_tdata   = {6'd0, o_cbytes_q, o_cfrom_q, o_outc_q, o_res_q};

	always_ff @(posedge clk) begin
		if (we) begin
			hdr_mem[waddr[SLOT_W+2:3]] <= wdata;
		end
		rd_q <= hdr_mem[raddr[SLOT_W+2:3]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			top_q     <= '0;
			limit_q   <= LIMIT_RESET;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (load_out) begin
				o_valid_q <= 1'b1;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= s_tdata[1:0];
			n_q    <= n_in;
			addr_q <= s_tdata[33:18];
		end
		mode_q   <= mode_d;
		h_q      <= h_d;
		cur_q    <= cur_d;
		acc_q    <= acc_d;
		blk_q    <= blk_d;
		tot_q    <= tot_d;
		na_q     <= na_d;
		prev_q   <= prev_d;
		res_q    <= res_d;
		outc_q   <= outc_d;
		cfrom_q  <= cfrom_d;
		cbytes_q <= cbytes_d;
		if (load_out) begin
			o_res_q    <= res_q;
			o_outc_q   <= outc_q;
			o_cfrom_q  <= cfrom_q;
			o_cbytes_q <= cbytes_q;
		end
	end

	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		h_d      = h_q;
		cur_d    = cur_q;
		acc_d    = acc_q;
		blk_d    = blk_q;
		tot_d    = tot_q;
		na_d     = na_q;
		top_d    = top_q;
		prev_d   = prev_q;
		res_d    = res_q;
		outc_d   = outc_q;
		cfrom_d  = cfrom_q;
		cbytes_d = cbytes_q;
		we       = 1'b0;
		waddr    = cur_q;
		wdata    = '0;
		raddr    = cur_q;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				res_d    = '0;
				outc_d   = OUT_DONE;
				cfrom_d  = '0;
				cbytes_d = '0;
				cur_d    = '0;
				h_d      = AW'(addr_q) - AW'(HDR_BYTES);
				if (op_q == OP_ALLOC || (op_q == OP_RESIZE && addr_q == '0)) begin
					mode_d  = M_ALLOC;
					state_d = (n_q == '0) ? S_FIN : S_AL_CHK;
				end else if (op_q == OP_FREE || op_q == OP_RESIZE) begin
					mode_d = (op_q == OP_FREE) ? M_FREE : M_RESIZE;
					// payload offsets sit 8 past an 8-aligned header
					if (addr_q >= 16'(HDR_BYTES) && addr_q[2:0] == 3'd0) begin
						state_d = S_CH_CHK;
					end else begin
						if (op_q == OP_RESIZE) begin
							outc_d = OUT_NOMEM;
						end
						state_d = S_FIN;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			// look for the block on the chain
			S_CH_CHK: begin
				if (cur_q < top_q && cur_q == h_q) begin
					if (mode_q == M_FREE || n_q == '0) begin
						mode_d  = M_FREE;
						state_d = S_REL_RD;
					end else begin
						raddr   = h_q;
						state_d = S_RS_PREV;
					end
				end else if (cur_q < top_q && cur_q < h_q) begin
					state_d = S_CH_ADV;
				end else begin
					if (mode_q == M_RESIZE) begin
						outc_d = OUT_NOMEM;
					end
					state_d = S_FIN;
				end
			end
			S_CH_ADV: begin
				cur_d   = step;
				state_d = S_CH_CHK;
			end
			// resize in place where it can
			S_RS_PREV: begin
				prev_d = rd_q[15:0];
				res_d  = addr_q;
				if (n_q < rsize) begin
					blk_d   = h_q;
					tot_d   = rsize;
					state_d = (fit_rem >= AW'(MIN_SPLIT)) ? S_SPLIT1 : S_FIN;
				end else if (n_q == rsize) begin
					state_d = S_FIN;
				end else begin
					acc_d   = rsize;
					cur_d   = step;
					state_d = S_RS_CHK;
				end
			end
			S_RS_CHK: begin
				state_d = (cur_q < top_q) ? S_RS_EVAL : S_RS_TOP;
			end
			S_RS_EVAL: begin
				if (rused) begin
					state_d = S_RS_TOP;
				end else begin
					acc_d = accstep;
					if (accstep >= n_q) begin
						if (accstep - n_q >= AW'(MIN_SPLIT)) begin
							blk_d   = h_q;
							tot_d   = accstep;
							state_d = S_SPLIT1;
						end else begin
							we      = 1'b1;
							waddr   = h_q;
							wdata   = {1'b1, accstep[15:0]};
							state_d = S_FIN;
						end
					end else begin
						cur_d   = step;
						state_d = S_RS_CHK;
					end
				end
			end
			S_RS_TOP: begin
				if (cur_q == top_q && h_q + AW'(HDR_BYTES) + n_q <= lim) begin
					we      = 1'b1;
					waddr   = h_q;
					wdata   = {1'b1, n_q[15:0]};
					top_d   = h_q + AW'(HDR_BYTES) + n_q;
					state_d = S_FIN;
				end else begin
					mode_d  = M_MOVE;
					cur_d   = '0;
					state_d = S_AL_CHK;
				end
			end
			// first-fit walk, then growth at the top
			S_AL_CHK: begin
				if (cur_q < top_q) begin
					state_d = S_AL_EVAL;
				end else if (top_q + AW'(HDR_BYTES) + n_q > lim) begin
					res_d   = '0;
					outc_d  = OUT_NOMEM;
					state_d = S_FIN;
				end else begin
					we      = 1'b1;
					waddr   = top_q;
					wdata   = {1'b1, n_q[15:0]};
					na_d    = top_q + AW'(HDR_BYTES);
					top_d   = top_q + AW'(HDR_BYTES) + n_q;
					state_d = S_AL_DONE;
				end
			end
			S_AL_EVAL: begin
				if (!rused && rsize >= n_q) begin
					blk_d = cur_q;
					na_d  = cur_q + AW'(HDR_BYTES);
					tot_d = rsize;
					if (fit_rem >= AW'(MIN_SPLIT)) begin
						state_d = S_SPLIT1;
					end else begin
						we      = 1'b1;
						waddr   = cur_q;
						wdata   = {1'b1, rd_q[15:0]};
						state_d = S_AL_DONE;
					end
				end else begin
					cur_d   = step;
					state_d = S_AL_CHK;
				end
			end
			S_SPLIT1: begin
				we      = 1'b1;
				waddr   = blk_q;
				wdata   = {1'b1, n_q[15:0]};
				state_d = S_SPLIT2;
			end
			S_SPLIT2: begin
				we      = 1'b1;
				waddr   = blk_q + AW'(HDR_BYTES) + n_q;
				wdata   = {1'b0, 16'(tot_q - n_q - AW'(HDR_BYTES))};
				state_d = (mode_q == M_RESIZE) ? S_FIN : S_AL_DONE;
			end
			S_AL_DONE: begin
				if (mode_q == M_MOVE) begin
					state_d = S_REL_RD;
				end else begin
					res_d   = na_q[15:0];
					state_d = S_FIN;
				end
			end
			// free and merge the free followers
			S_REL_RD: begin
				raddr   = h_q;
				cur_d   = h_q;
				state_d = S_REL_SZ;
			end
			S_REL_SZ: begin
				acc_d   = rsize;
				cur_d   = step;
				state_d = S_REL_CHK;
			end
			S_REL_CHK: begin
				state_d = (cur_q < top_q) ? S_REL_NX : S_REL_WR;
			end
			S_REL_NX: begin
				if (!rused) begin
					acc_d   = accstep;
					cur_d   = step;
					state_d = S_REL_CHK;
				end else begin
					state_d = S_REL_WR;
				end
			end
			S_REL_WR: begin
				we    = 1'b1;
				waddr = h_q;
				wdata = {1'b0, acc_q[15:0]};
				if (mode_q == M_MOVE) begin
					res_d    = na_q[15:0];
					outc_d   = OUT_MOVED;
					cfrom_d  = addr_q;
					cbytes_d = prev_q;
				end
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!o_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// the top only ever moves within the arena and stays 8-aligned
	assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= AW'(HEAP_BYTES) && top_q[2:0] == 3'd0)
		else $error("heap top out of arena or misaligned");

	// a transaction is taken only when no earlier request is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while busy");

	// a moved block always reports its source and its new address
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[17:16] == OUT_MOVED) |-> (m_tdata[33:18] != 16'd0
		&& m_tdata[15:0] != 16'd0))
		else $error("move result without addresses");

	// only growth writes change the top
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> $stable(top_q))
		else $error("heap top changed while idle");

endmodule
